### src/vfnm_pkg.sv
`default_nettype none
package vfnm_pkg;

   localparam int SIZE_W  = 7;
   localparam int PLANE_W = 14;
   localparam int DIR_W   = 6;
   localparam int CSR_W   = 3;

   localparam logic [CSR_W-1:0] CSR_SIZE_X   = 3'd0;
   localparam logic [CSR_W-1:0] CSR_SIZE_Y   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_SIZE_Z   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_DIR_MASK = 3'd3;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;
   localparam logic [DIR_W-1:0]  DIR_RST  = 6'd63;

   // self read, then the six face neighbours, then the last read returns
   typedef enum logic [3:0] {
      S_IDLE,
      S_SELF,
      S_XHI,
      S_XLO,
      S_YHI,
      S_YLO,
      S_ZHI,
      S_ZLO,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0] i;
      logic [SIZE_W-1:0] j;
      logic [SIZE_W-1:0] k;
      logic              last;
   } coord_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [8:0] maxv);
      if (v == '0) begin
         return 7'd1;
      end else if ({2'b00, v} > maxv) begin
         return maxv[SIZE_W-1:0];
      end else begin
         return v;
      end
   endfunction

endpackage
`default_nettype wire

### src/vfnm_raster_cnt.sv
`default_nettype none
module vfnm_raster_cnt #(
   parameter int AW = 18
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       clear,
   input  wire logic                       advance,
   input  wire logic [vfnm_pkg::SIZE_W-1:0] sx,
   input  wire logic [vfnm_pkg::SIZE_W-1:0] sy,
   input  wire logic [vfnm_pkg::SIZE_W-1:0] sz,
   output logic      [AW-1:0]              pos,
   output vfnm_pkg::coord_type             coord
);

   logic [AW-1:0]                pos_ff, pos_in;
   logic [vfnm_pkg::SIZE_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                         i_end, j_end, k_end, all_end;

   assign i_end   = (i_ff + 7'd1) == sx;
   assign j_end   = (j_ff + 7'd1) == sy;
   assign k_end   = (k_ff + 7'd1) == sz;
   assign all_end = i_end & j_end & k_end;

   always_comb begin
      pos_in = pos_ff;
      i_in   = i_ff;
      j_in   = j_ff;
      k_in   = k_ff;
      if (clear) begin
         pos_in = '0;
         i_in   = '0;
         j_in   = '0;
         k_in   = '0;
      end else if (advance) begin
         if (all_end) begin
            pos_in = '0;
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
         end else begin
            pos_in = pos_ff + AW'(1);
            if (k_end) begin
               k_in = '0;
               if (j_end) begin
                  j_in = '0;
                  i_in = i_ff + 7'd1;
               end else begin
                  j_in = j_ff + 7'd1;
               end
            end else begin
               k_in = k_ff + 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         i_ff   <= '0;
         j_ff   <= '0;
         k_ff   <= '0;
      end else begin
         pos_ff <= pos_in;
         i_ff   <= i_in;
         j_ff   <= j_in;
         k_ff   <= k_in;
      end
   end

   assign pos        = pos_ff;
   assign coord.i    = i_ff;
   assign coord.j    = j_ff;
   assign coord.k    = k_ff;
   assign coord.last = all_end;

endmodule
`default_nettype wire

### src/vfnm_vol_mem.sv
`default_nettype none
module vfnm_vol_mem #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [1:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [1:0]    rd_data
);

   // bit 1 occupancy, bit 0 prior mark
   logic [1:0] mem [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/voxel_face_neighbour_mark.sv
`default_nettype none
// 6-connected face dilation over a voxel volume held in one on-chip store.
// Input channel: start/busy with req_cmd, req_occupied, req_prior_mark. A beat
// is taken when start is high and busy is low.
//   load (req_cmd 0): writes one voxel in raster order (z fastest); busy
//   stays low, no result.
//   emit (req_cmd 1): busy while a shared address adder walks the store's
//   single read port over the voxel and its six face neighbours (7 reads,
//   then a final state in which the last read returns and the result is
//   registered).
//   rsp_valid pulses in the cycle after that state, when busy is low again,
//   with rsp_mark and rsp_last. Emits do not overlap; the read port limits them.
// Results cannot be held off; rsp_valid is a single-cycle strobe.
// Config channel: csr_valid/csr_ready (always ready), csr_index, csr_wdata;
// write only while idle. Writing a size returns load and emit positions to 0.
// Reset: sizes 64, all directions on, positions 0. Store contents are not
// cleared; emit only voxels that were loaded.
module voxel_face_neighbour_mark #(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64,
   parameter int MAX_Z = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_cmd,
   input  wire logic                       req_occupied,
   input  wire logic                       req_prior_mark,
   output logic                            rsp_valid,
   output logic                            rsp_mark,
   output logic                            rsp_last,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [vfnm_pkg::CSR_W-1:0]  csr_index,
   input  wire logic [vfnm_pkg::SIZE_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [vfnm_pkg::SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [vfnm_pkg::DIR_W-1:0]   dir_mask_ff;
   logic [vfnm_pkg::SIZE_W-1:0]  sx_c, sy_c, sz_c;
   logic                         csr_wr, size_clear;

   logic                         accept, load_go, emit_go, finish;
   vfnm_pkg::state_type          state_ff, state_in;

   logic [AW-1:0]                load_pos, emit_pos, rd_addr, off_aw;
   vfnm_pkg::coord_type          ec;
   logic [vfnm_pkg::PLANE_W-1:0] plane_ff, plane_in, off;
   logic                         sub, chk, is_self;
   logic                         chk_ff, self_ff;
   logic [1:0]                   rd_data;
   logic                         occ_self_ff, prior_ff, hit_ff, hit_now, mark_now;
   logic                         rsp_valid_ff, rsp_mark_ff, rsp_last_ff;

   // ---------------- config ----------------
   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid & csr_ready;
   assign size_clear = csr_wr && (csr_index == vfnm_pkg::CSR_SIZE_X ||
                                  csr_index == vfnm_pkg::CSR_SIZE_Y ||
                                  csr_index == vfnm_pkg::CSR_SIZE_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= vfnm_pkg::SIZE_RST;
         size_y_ff   <= vfnm_pkg::SIZE_RST;
         size_z_ff   <= vfnm_pkg::SIZE_RST;
         dir_mask_ff <= vfnm_pkg::DIR_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            vfnm_pkg::CSR_SIZE_X:   size_x_ff   <= csr_wdata;
            vfnm_pkg::CSR_SIZE_Y:   size_y_ff   <= csr_wdata;
            vfnm_pkg::CSR_SIZE_Z:   size_z_ff   <= csr_wdata;
            vfnm_pkg::CSR_DIR_MASK: dir_mask_ff <= csr_wdata[vfnm_pkg::DIR_W-1:0];
            default: ;
         endcase
      end
   end

   assign sx_c = vfnm_pkg::clamp_size(size_x_ff, 9'(MAX_X));
   assign sy_c = vfnm_pkg::clamp_size(size_y_ff, 9'(MAX_Y));
   assign sz_c = vfnm_pkg::clamp_size(size_z_ff, 9'(MAX_Z));

   // ---------------- positions ----------------
   assign accept  = start & ~busy;
   assign load_go = accept && (req_cmd == vfnm_pkg::CMD_LOAD);
   assign emit_go = accept && (req_cmd == vfnm_pkg::CMD_EMIT);

   vfnm_raster_cnt #(.AW(AW)) u_load_cnt (
      .clock   (clock),
      .reset   (reset),
      .clear   (size_clear),
      .advance (load_go),
      .sx      (sx_c),
      .sy      (sy_c),
      .sz      (sz_c),
      .pos     (load_pos),
      .coord   ()
   );

   vfnm_raster_cnt #(.AW(AW)) u_emit_cnt (
      .clock   (clock),
      .reset   (reset),
      .clear   (size_clear),
      .advance (finish),
      .sx      (sx_c),
      .sy      (sy_c),
      .sz      (sz_c),
      .pos     (emit_pos),
      .coord   (ec)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vfnm_pkg::S_IDLE:   if (emit_go) state_in = vfnm_pkg::S_SELF;
         vfnm_pkg::S_SELF:   state_in = vfnm_pkg::S_XHI;
         vfnm_pkg::S_XHI:    state_in = vfnm_pkg::S_XLO;
         vfnm_pkg::S_XLO:    state_in = vfnm_pkg::S_YHI;
         vfnm_pkg::S_YHI:    state_in = vfnm_pkg::S_YLO;
         vfnm_pkg::S_YLO:    state_in = vfnm_pkg::S_ZHI;
         vfnm_pkg::S_ZHI:    state_in = vfnm_pkg::S_ZLO;
         vfnm_pkg::S_ZLO:    state_in = vfnm_pkg::S_FINISH;
         vfnm_pkg::S_FINISH: state_in = vfnm_pkg::S_IDLE;
         default:            state_in = vfnm_pkg::S_IDLE;
      endcase
   end

   // neighbour on the far side of each enabled direction
   always_comb begin
      off     = '0;
      sub     = 1'b0;
      chk     = 1'b0;
      is_self = 1'b0;
      busy    = 1'b1;
      finish  = 1'b0;
      unique case (state_ff)
         vfnm_pkg::S_SELF: is_self = 1'b1;
         vfnm_pkg::S_XHI: begin
            off = plane_ff;
            chk = dir_mask_ff[0] && ((ec.i + 7'd1) < sx_c);
         end
         vfnm_pkg::S_XLO: begin
            off = plane_ff;
            sub = 1'b1;
            chk = dir_mask_ff[1] && (ec.i != '0);
         end
         vfnm_pkg::S_YHI: begin
            off = vfnm_pkg::PLANE_W'(sz_c);
            chk = dir_mask_ff[2] && ((ec.j + 7'd1) < sy_c);
         end
         vfnm_pkg::S_YLO: begin
            off = vfnm_pkg::PLANE_W'(sz_c);
            sub = 1'b1;
            chk = dir_mask_ff[3] && (ec.j != '0);
         end
         vfnm_pkg::S_ZHI: begin
            off = vfnm_pkg::PLANE_W'(1);
            chk = dir_mask_ff[4] && ((ec.k + 7'd1) < sz_c);
         end
         vfnm_pkg::S_ZLO: begin
            off = vfnm_pkg::PLANE_W'(1);
            sub = 1'b1;
            chk = dir_mask_ff[5] && (ec.k != '0);
         end
         vfnm_pkg::S_FINISH: finish = 1'b1;
         vfnm_pkg::S_IDLE:   busy   = 1'b0;
         default:            busy   = 1'b0;
      endcase
   end

   // shared address adder
   assign off_aw  = AW'(off);
   assign rd_addr = emit_pos + (off_aw ^ {AW{sub}}) + AW'(sub);

   assign plane_in = emit_go ? (vfnm_pkg::PLANE_W'(sy_c) * vfnm_pkg::PLANE_W'(sz_c))
                             : plane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfnm_pkg::S_IDLE;
         chk_ff       <= 1'b0;
         self_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk;
         self_ff      <= is_self;
         rsp_valid_ff <= finish;
      end
   end

   vfnm_vol_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (load_pos),
      .wr_data ({req_occupied, req_prior_mark}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- accumulate ----------------
   assign hit_now  = hit_ff | (chk_ff & rd_data[1]);
   assign mark_now = prior_ff | (~occ_self_ff & hit_now);

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
      hit_ff   <= self_ff ? 1'b0 : hit_now;
      if (self_ff) begin
         occ_self_ff <= rd_data[1];
         prior_ff    <= rd_data[0];
      end
      if (finish) begin
         rsp_mark_ff <= mark_now;
         rsp_last_ff <= ec.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mark  = rsp_mark_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
`default_nettype wire

### src/vfnm_check.sv
`default_nettype none
module vfnm_check (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_cmd,
   input wire logic rsp_valid
);

   // emit occupies the block until its result
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == vfnm_pkg::CMD_EMIT) |=> busy)
      else $error("emit beat did not raise busy");

   // loads do not raise busy
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == vfnm_pkg::CMD_LOAD) |=> !busy)
      else $error("load beat raised busy");

   // every emit ends with a result
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy fell without a result");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind voxel_face_neighbour_mark vfnm_check u_vfnm_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_cmd   (req_cmd),
   .rsp_valid (rsp_valid)
);
`default_nettype wire
